// ===== src/bblc_pkg.sv =====
package bblc_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W = 13;
  localparam int SIZE_W = 27;
  localparam int SEQ_W = 64;
  localparam int PAD_W = 12;
  localparam int TOT_W = 32;
  localparam int EV_W = 5;

  typedef enum logic [1:0] {
    OP_PUT = 2'd0,
    OP_PUT_CROP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_GET = 2'd3
  } op_t;

  localparam logic [1:0] REG_BUDGET = 2'd0;
  localparam logic [1:0] REG_PINNED = 2'd1;
  localparam logic [31:0] BUDGET_RESET = 32'd67108864;

  // request that starts one walk of the shared compare unit
  typedef struct packed {
    logic             start;
    logic [SLOTS-1:0] cand;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] best;
  } scan_rsp_t;
endpackage

// ===== src/bblc_scan.sv =====
module bblc_scan
  import bblc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  scan_req_t                  req,
  input  logic [SLOTS-1:0][SEQ_W-1:0] seqs,
  output scan_rsp_t                  rsp
);
  // walks the candidates one slot a cycle with a single 64-bit compare
  logic              busy_r;
  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] best_r;
  logic [SEQ_W-1:0]  best_seq_r;
  logic              done_r;
  logic              take;

  assign take = req.cand[idx_r] && (!found_r || seqs[idx_r] < best_seq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        idx_r <= '0;
        found_r <= 1'b0;
      end else if (busy_r) begin
        if (take) begin
          found_r <= 1'b1;
          best_r <= idx_r;
          best_seq_r <= seqs[idx_r];
        end
        if (idx_r == SLOT_W'(SLOTS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.found = found_r;
  assign rsp.best = best_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r)) else $error("scan done without walk");
  a_found_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && take) |=> found_r) else $error("best lost");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r) else $error("scan busy after done");
endmodule

// ===== src/byte_budget_layer_cache.sv =====
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready  | op, layer, sizes, padding, seq_no
// out_    | output    | out_valid/out_ready  | accepted, present, stored_*, total_used, evicted
// cfg_    | input     | apb psel/penable     | byte_budget @0x0, pinned_layers @0x4
// gets, updates and puts rejected on their sides go from the multiply state straight to the output state
// a put over budget leaves from the check state, a put that fits without eviction passes wait and commit
// each eviction passes the wait state and a walk over all slots through the shared sequence compare;
// a put evicts at most 15 slots, and a walk that finds no candidate rejects the put
// in_ready is low from acceptance until the result is taken at out_
// synchronous active-low reset empties all slots and restores the registers
module byte_budget_layer_cache
  import bblc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_layer,
  input  logic [12:0]       in_width,
  input  logic [12:0]       in_height,
  input  logic [12:0]       in_canvas_width,
  input  logic [12:0]       in_canvas_height,
  input  logic [11:0]       in_padding,
  input  logic [63:0]       in_seq_no,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accepted,
  output logic              out_present,
  output logic [26:0]       out_stored_bytes,
  output logic [12:0]       out_stored_width,
  output logic [12:0]       out_stored_height,
  output logic [11:0]       out_stored_padding,
  output logic [63:0]       out_stored_seq,
  output logic [31:0]       out_total_used,
  output logic [4:0]        out_evicted,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CHECK, S_SCAN, S_WAIT, S_COMMIT, S_OUT
  } state_t;

  state_t            state_r;
  logic [31:0]       budget_r;
  logic [15:0]       pinned_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0][SIZE_W-1:0] size_r;
  logic [SLOTS-1:0][SEQ_W-1:0]  seq_r;
  logic [SLOTS-1:0][SIDE_W-1:0] wid_r;
  logic [SLOTS-1:0][SIDE_W-1:0] hgt_r;
  logic [SLOTS-1:0][PAD_W-1:0]  pad_r;
  logic [TOT_W-1:0]  used_r;

  op_t               op_r;
  logic [SLOT_W-1:0] lay_r;
  logic [SIDE_W-1:0] w_r, h_r, cw_r, ch_r;
  logic [PAD_W-1:0]  pd_r;
  logic [SEQ_W-1:0]  cs_r;
  logic [SIZE_W-1:0] need_r;
  logic [33:0]       retained_r;
  logic [33:0]       limit_r;
  logic [SLOTS-1:0]  chosen_r;
  logic [EV_W-1:0]   ev_r;
  logic              ok_r;
  logic              out_valid_r;

  scan_req_t sreq;
  scan_rsp_t srsp;
  logic [SLOTS-1:0] cand;
  logic good, crop_ok, fits;
  logic [SIZE_W-1:0] existing;

  always_comb begin
    for (int i = 0; i < SLOTS; i++)
      cand[i] = valid_r[i] && (SLOT_W'(i) != lay_r) && !pinned_r[i] && !chosen_r[i];
  end

  assign crop_ok = w_r != 0 && h_r != 0 && cw_r != 0 && ch_r != 0 && w_r <= cw_r
                   && h_r <= ch_r;
  assign good = w_r != 0 && h_r != 0 && w_r <= SIDE_W'(MAX_SIDE)
                && h_r <= SIDE_W'(MAX_SIDE) && (op_r != OP_PUT_CROP || crop_ok);
  assign existing = valid_r[lay_r] ? size_r[lay_r] : '0;
  // retained shrinks by each chosen slot, limit is the room left beside the new bitmap
  assign fits = retained_r <= limit_r;

  // one start pulse per walk, on the way into the scan state
  assign sreq.start = (state_r == S_WAIT) && !fits;
  assign sreq.cand = cand;

  bblc_scan u_scan (.clk(clk), .rst_n(rst_n), .req(sreq), .seqs(seq_r), .rsp(srsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      budget_r <= BUDGET_RESET;
      pinned_r <= '0;
      valid_r <= '0;
      used_r <= '0;
      ev_r <= '0;
      ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[2:2])
          REG_BUDGET[0:0]: budget_r <= cfg_pwdata;
          REG_PINNED[0:0]: pinned_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= op_t'(in_op);
            lay_r <= in_layer;
            w_r <= in_width;
            h_r <= in_height;
            cw_r <= in_canvas_width;
            ch_r <= in_canvas_height;
            pd_r <= in_padding;
            cs_r <= in_seq_no;
            chosen_r <= '0;
            ev_r <= '0;
            ok_r <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // sides are at most MAX_SIDE here when they matter
          need_r <= (SIZE_W'(w_r) * SIZE_W'(h_r)) << 2;
          retained_r <= (used_r >= TOT_W'(existing)) ?
                        34'(used_r - TOT_W'(existing)) : '0;
          if (op_r == OP_GET) begin
            ok_r <= valid_r[lay_r];
            state_r <= S_OUT;
          end else if (op_r == OP_UPDATE) begin
            if (crop_ok && valid_r[lay_r] && wid_r[lay_r] == w_r
                && hgt_r[lay_r] == h_r && pad_r[lay_r] == pd_r) begin
              seq_r[lay_r] <= cs_r;
              ok_r <= 1'b1;
            end
            state_r <= S_OUT;
          end else if (good) begin
            state_r <= S_CHECK;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_CHECK: begin
          if (32'(need_r) > budget_r) state_r <= S_OUT;
          else begin
            limit_r <= 34'(budget_r - 32'(need_r));
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (fits) state_r <= S_COMMIT;
          else state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (srsp.done) begin
            if (srsp.found) begin
              chosen_r[srsp.best] <= 1'b1;
              retained_r <= retained_r - 34'(size_r[srsp.best]);
              ev_r <= ev_r + 1'b1;
              state_r <= S_WAIT;
            end else begin
              ev_r <= '0;
              state_r <= S_OUT;
            end
          end
        end
        S_COMMIT: begin
          valid_r <= (valid_r & ~chosen_r) | (SLOTS'(1) << lay_r);
          used_r <= TOT_W'(retained_r) + TOT_W'(need_r);
          size_r[lay_r] <= need_r;
          wid_r[lay_r] <= w_r;
          hgt_r[lay_r] <= h_r;
          pad_r[lay_r] <= (op_r == OP_PUT_CROP) ? pd_r : '0;
          seq_r[lay_r] <= cs_r;
          ok_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) out_valid_r <= 1'b1;
          else if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_accepted = ok_r;
  assign out_present = valid_r[lay_r];
  assign out_stored_bytes = valid_r[lay_r] ? size_r[lay_r] : '0;
  assign out_stored_width = valid_r[lay_r] ? wid_r[lay_r] : '0;
  assign out_stored_height = valid_r[lay_r] ? hgt_r[lay_r] : '0;
  assign out_stored_padding = valid_r[lay_r] ? pad_r[lay_r] : '0;
  assign out_stored_seq = valid_r[lay_r] ? seq_r[lay_r] : '0;
  assign out_total_used = used_r;
  assign out_evicted = ok_r ? ev_r : '0;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2:2] == REG_PINNED[0:0]) ? {16'd0, pinned_r} : budget_r;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |-> fits) else $error("commit without room");
  a_ev_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ev_r <= EV_W'(SLOTS)) else $error("eviction count overrun");
endmodule
